>>> design/sss_pkg.sv
// Package for the sensor to servo smoother: default sizes, reset values,
// configuration register indexes and the configuration struct.
// No dependencies.
package sss_pkg;

    localparam int BLOCK_SAMPLES_DEF = 25;
    localparam int WINDOW_TAPS_DEF   = 10;
    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int PULSE_W           = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [PULSE_W-1:0] PULSE_AT_ZERO_RST = 16'd3800;
    localparam logic [PULSE_W-1:0] PULSE_AT_FULL_RST = 16'd1835;
    localparam logic [PULSE_W-1:0] RING_RST          = 16'd1835;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_AT_ZERO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_AT_FULL = 1'b1;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_at_zero;
        logic [PULSE_W-1:0] pulse_at_full;
    } cfg_t;

endpackage

>>> design/sss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/sss_front.sv
// Front end: accepts samples and sums them into blocks; pushes each
// finished block sum into the queue. Depends on nothing else.
module sss_front #(
    parameter int BLOCK_SAMPLES = 25,
    parameter int SAMPLE_BITS   = 12
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  logic [SAMPLE_BITS-1:0]                        sample,
    input  logic                                          q_full,
    output logic                                          push,
    output logic [SAMPLE_BITS+$clog2(BLOCK_SAMPLES)-1:0]  push_sum
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(BLOCK_SAMPLES);
    localparam int CNT_W = ($clog2(BLOCK_SAMPLES) > 0) ? $clog2(BLOCK_SAMPLES) : 1;

    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             last;
    logic             accept;

    assign last     = (count_reg == CNT_W'(BLOCK_SAMPLES - 1));
    assign in_stall = q_full && last;
    assign accept   = in_valid && !in_stall;
    assign sum_next = sum_reg + SUM_W'(sample);
    assign push     = accept && last;
    assign push_sum = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_next;
            end
        end
    end

endmodule

>>> design/sss_queue.sv
// Short register queue that holds block sums between front and back end.
// No dependencies.
module sss_queue #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output logic [WIDTH-1:0] data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign data    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/sss_back.sv
// Back end: per block sum, divide to the average, map onto the pulse range,
// update the window ring and emit the window mean. Depends on sss_pkg, sss_ram.
module sss_back #(
    parameter int BLOCK_SAMPLES = 25,
    parameter int WINDOW_TAPS   = 10,
    parameter int SAMPLE_BITS   = 12
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  sss_pkg::cfg_t                                cfg,
    input  logic                                         q_valid,
    input  logic [SAMPLE_BITS+$clog2(BLOCK_SAMPLES)-1:0] q_data,
    output logic                                         pop,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic [sss_pkg::PULSE_W-1:0]                  pulse_width,
    output logic [SAMPLE_BITS-1:0]                       block_average
);

    import sss_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(BLOCK_SAMPLES);
    localparam int S1    = SUM_W + $clog2(BLOCK_SAMPLES);
    localparam int P1_W  = 2 * SUM_W + 1;
    localparam logic [63:0] M1_FULL =
        ((64'd1 << S1) + 64'(BLOCK_SAMPLES) - 64'd1) / 64'(BLOCK_SAMPLES);
    localparam logic [SUM_W:0] M1 = M1_FULL[SUM_W:0];

    localparam int MAP_W      = SAMPLE_BITS + PULSE_W;
    localparam int FULL_SCALE = (1 << SAMPLE_BITS) - 1;
    localparam int S2         = MAP_W + SAMPLE_BITS;
    localparam int P2_W       = 2 * MAP_W + 1;
    localparam logic [63:0] M2_FULL =
        ((64'd1 << S2) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
    localparam logic [MAP_W:0] M2 = M2_FULL[MAP_W:0];

    localparam int TAP_BITS = $clog2(WINDOW_TAPS);
    localparam int POS_W    = (TAP_BITS > 0) ? TAP_BITS : 1;
    localparam int TOT_W    = PULSE_W + TAP_BITS;
    localparam int S3       = TOT_W + TAP_BITS;
    localparam int P3_W     = 2 * TOT_W + 1;
    localparam logic [63:0] M3_FULL =
        ((64'd1 << S3) + 64'(WINDOW_TAPS) - 64'd1) / 64'(WINDOW_TAPS);
    localparam logic [TOT_W:0] M3 = M3_FULL[TOT_W:0];
    localparam logic [TOT_W-1:0] TOTAL_RST = TOT_W'(WINDOW_TAPS * int'(RING_RST));

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV1 = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV2 = 3'd3;
    localparam logic [2:0] ST_MAP  = 3'd4;
    localparam logic [2:0] ST_RING = 3'd5;
    localparam logic [2:0] ST_MEAN = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [P1_W-1:0]        prod1_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic                   neg_reg;
    logic [PULSE_W-1:0]     mag_reg;
    logic [MAP_W-1:0]       mprod_reg;
    logic [P2_W-1:0]        prod2_reg;
    logic [PULSE_W-1:0]     mapped_reg;
    logic [PULSE_W-1:0]     mapped_next;
    logic [P3_W-1:0]        prod3_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic [WINDOW_TAPS-1:0] valid_reg;
    logic [TOT_W-1:0]       total_reg;
    logic [TOT_W-1:0]       total_next;
    logic                   out_valid_reg;
    logic [PULSE_W-1:0]     pulse_width_reg;
    logic [SAMPLE_BITS-1:0] block_average_reg;

    logic [PULSE_W:0]       span;
    logic [PULSE_W:0]       span_neg;
    logic [PULSE_W-1:0]     scaled;
    logic [PULSE_W-1:0]     ring_rd_data;
    logic [PULSE_W-1:0]     old_entry;
    logic                   out_free;
    logic                   load_out;

    assign span        = {1'b0, cfg.pulse_at_full} - {1'b0, cfg.pulse_at_zero};
    assign span_neg    = ~span + 1'b1;
    assign scaled      = prod2_reg[S2 +: PULSE_W];
    assign mapped_next = neg_reg ? (cfg.pulse_at_zero - scaled) : (cfg.pulse_at_zero + scaled);
    assign old_entry   = valid_reg[pos_reg] ? ring_rd_data : RING_RST;
    assign total_next  = total_reg - TOT_W'(old_entry) + TOT_W'(mapped_reg);
    assign pos_next    = (pos_reg == POS_W'(WINDOW_TAPS - 1)) ? '0 : pos_reg + 1'b1;
    assign out_free    = !out_valid_reg || !out_stall;
    assign pop         = (state_reg == ST_IDLE) && q_valid;
    assign load_out    = (state_reg == ST_OUT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_DIV1;
            ST_DIV1: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV2;
            ST_DIV2: state_next = ST_MAP;
            ST_MAP:  state_next = ST_RING;
            ST_RING: state_next = ST_MEAN;
            ST_MEAN: state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    sss_ram #(
        .WIDTH(PULSE_W),
        .DEPTH(WINDOW_TAPS)
    ) u_ring (
        .clk    (clk),
        .wr_en  (state_reg == ST_RING),
        .wr_addr(pos_reg),
        .wr_data(mapped_reg),
        .rd_en  (state_reg == ST_DIV1),
        .rd_addr(pos_reg),
        .rd_data(ring_rd_data)
    );

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE: prod1_reg <= P1_W'(q_data) * P1_W'(M1);
            ST_DIV1:
            begin
                avg_reg <= prod1_reg[S1 +: SAMPLE_BITS];
                neg_reg <= span[PULSE_W];
                mag_reg <= span[PULSE_W] ? span_neg[PULSE_W-1:0] : span[PULSE_W-1:0];
            end
            ST_MUL:  mprod_reg  <= MAP_W'(avg_reg) * MAP_W'(mag_reg);
            ST_DIV2: prod2_reg  <= P2_W'(mprod_reg) * P2_W'(M2);
            ST_MAP:  mapped_reg <= mapped_next;
            ST_RING: ;
            ST_MEAN: prod3_reg  <= P3_W'(total_reg) * P3_W'(M3);
            ST_OUT:
            begin
                if (out_free)
                begin
                    pulse_width_reg   <= prod3_reg[S3 +: PULSE_W];
                    block_average_reg <= avg_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            valid_reg     <= '0;
            total_reg     <= TOTAL_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_RING)
            begin
                total_reg          <= total_next;
                valid_reg[pos_reg] <= 1'b1;
                pos_reg            <= pos_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign pulse_width   = pulse_width_reg;
    assign block_average = block_average_reg;

endmodule

>>> design/sensor_to_servo_smoother_top.sv
// Result path: a block sum passes the queue, then back-end states IDLE, DIV1,
// MUL, DIV2, MAP, RING, MEAN and OUT. One sample word per cycle while in_stall
// is low; the back end takes a new block sum only after OUT of the previous one.
// Reset (async, rst_n low): block sum and count clear, ring entries read as
// 1835 until written, ring total 1835 per tap, registers to 3800 and 1835.
// Depends on sss_pkg, sss_front, sss_queue, sss_back.
module sensor_to_servo_smoother_top #(
    parameter int BLOCK_SAMPLES = sss_pkg::BLOCK_SAMPLES_DEF,
    parameter int WINDOW_TAPS   = sss_pkg::WINDOW_TAPS_DEF,
    parameter int SAMPLE_BITS   = sss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sss_pkg::PULSE_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sss_pkg::PULSE_W-1:0]   pulse_width,
    output logic [SAMPLE_BITS-1:0]        block_average
);

    import sss_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(BLOCK_SAMPLES);

    cfg_t             cfg_reg;
    logic             push;
    logic [SUM_W-1:0] push_sum;
    logic             q_full;
    logic             q_valid;
    logic [SUM_W-1:0] q_data;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_at_zero <= PULSE_AT_ZERO_RST;
            cfg_reg.pulse_at_full <= PULSE_AT_FULL_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PULSE_AT_ZERO: cfg_reg.pulse_at_zero <= cfg_data;
                CFG_PULSE_AT_FULL: cfg_reg.pulse_at_full <= cfg_data;
                default: ;
            endcase
        end
    end

    sss_front #(
        .BLOCK_SAMPLES(BLOCK_SAMPLES),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample  (sample),
        .q_full  (q_full),
        .push    (push),
        .push_sum(push_sum)
    );

    sss_queue #(
        .WIDTH(SUM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_sum),
        .pop      (pop),
        .full     (q_full),
        .valid    (q_valid),
        .data     (q_data)
    );

    sss_back #(
        .BLOCK_SAMPLES(BLOCK_SAMPLES),
        .WINDOW_TAPS  (WINDOW_TAPS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pulse_width  (pulse_width),
        .block_average(block_average)
    );

endmodule

>>> design/sss_checker.sv
// Port-level checker for the smoother: result accounting against finished
// blocks and output hold under stall. Bound to sensor_to_servo_smoother_top.
module sss_checker #(
    parameter int BLOCK_SAMPLES = 25,
    parameter int SAMPLE_BITS   = 12
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [15:0]            pulse_width,
    input logic [SAMPLE_BITS-1:0] block_average
);

    localparam int CNT_W = ($clog2(BLOCK_SAMPLES) > 0) ? $clog2(BLOCK_SAMPLES) : 1;

    logic [CNT_W-1:0] count_reg;
    logic [3:0]       pending_reg;
    logic             in_take;
    logic             out_take;
    logic             block_done;

    assign in_take    = in_valid && !in_stall;
    assign out_take   = out_valid && !out_stall;
    assign block_done = in_take && (count_reg == CNT_W'(BLOCK_SAMPLES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                count_reg <= block_done ? '0 : count_reg + 1'b1;
            end
            if (block_done && !out_take)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (out_take && !block_done)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
        end
    end

    a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 4'd0))
        else $error("result word without a finished block");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd4)
        else $error("more blocks in flight than the design can hold");

    a_stall_only_when_backed_up: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (pending_reg >= 4'd2))
        else $error("input stalled while the queue cannot be full");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(pulse_width) && $stable(block_average)))
        else $error("stalled result word changed");

endmodule

bind sensor_to_servo_smoother_top sss_checker #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES),
    .SAMPLE_BITS  (SAMPLE_BITS)
) u_sss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pulse_width  (pulse_width),
    .block_average(block_average)
);
